[rtl/irt_cp_pkg.sv]
package irt_cp_pkg;

  typedef struct packed {
    logic signed [15:0] theta_0;
    logic signed [15:0] theta_1;
    logic signed [15:0] theta_2;
    logic signed [15:0] slope_0;
    logic signed [15:0] slope_1;
    logic signed [15:0] slope_2;
    logic signed [15:0] loading_0;
    logic signed [15:0] loading_1;
    logic signed [15:0] loading_2;
    logic signed [15:0] difficulty;
    logic [16:0]        guess_floor;
    logic [16:0]        slip_ceiling;
  } query_t;

  typedef struct packed {
    logic [16:0] probability;
    logic        logit_saturated;
  } result_t;

  localparam logic [16:0] ProbOne = 17'd65536;
  localparam logic signed [15:0] LogitMax = 16'sh7fff;
  localparam logic signed [15:0] LogitMin = 16'sh8000;

  // shift-subtract divide, only evaluated while building the logistic table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigma(-a/n) in Q0.16: taylor series of exp, eight squarings in Q1.31
  function automatic logic [16:0] neg_logistic(input logic [63:0] a, input logic [63:0] n);
    logic [63:0] s;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] q;
    s  = udiv64(a << 23, n);
    t2 = (s * s) >> 31;
    t3 = (t2 * s) >> 31;
    t4 = (t3 * s) >> 31;
    e  = (64'd1 << 31) - s + (t2 >> 1) - t3 / 64'd6 + t4 / 64'd24;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    den = (64'd1 << 31) + e;
    q   = udiv64(64'd65536 * e + (den >> 1), den);
    return q[16:0];
  endfunction

  // table entry k covers x = -8 + 16k/n
  function automatic logic [16:0] logistic_entry(input int n, input int k);
    int          num;
    logic [16:0] v;
    num = 16 * k - 8 * n;
    if (num <= 0) begin
      v = neg_logistic(64'(-num), 64'(n));
    end else begin
      v = ProbOne - neg_logistic(64'(num), 64'(n));
    end
    return v;
  endfunction

endpackage

[rtl/irt_cp_if.sv]
interface irt_cp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/irt_compensatory_probability.sv]
// Compensatory multidimensional 4PL response probability. Each query item carries an ability
// point and one test item's parameters; the block returns floor + (ceiling - floor) * sigma(logit)
// in Q0.16, where the logit is the sum of slope*loading*theta over the first DIMS dimensions
// minus the difficulty, rounded to Q4.12 and clipped to [-8, 8) (logit_saturated marks a clip).
// The logistic comes from a LOGISTIC_ENTRIES-segment table, built at elaboration, with linear
// interpolation. Six register stages: slope*loading, times theta, sum and round, table lookup,
// interpolation, asymptote scaling. One item enters per clock unless the result port stalls. Each stage
// stalls only when it holds an item that the next cannot take, so bubbles fill while the
// result port is held. No state is kept between items.
module irt_compensatory_probability
  import irt_cp_pkg::*;
#(
  parameter int DIMS             = 3,
  parameter int LOGISTIC_ENTRIES = 256
) (
  input logic       clk,
  input logic       rst,
  irt_cp_if.sink    query,
  irt_cp_if.source  result
);

  localparam int Stages = 6;
  localparam int KW     = $clog2(LOGISTIC_ENTRIES);
  localparam int TW     = 16 + KW;

  // logistic table, entry k and entry k+1 for each segment
  logic [16:0] lut_lo [LOGISTIC_ENTRIES];
  logic [16:0] lut_hi [LOGISTIC_ENTRIES];

  for (genvar k = 0; k < LOGISTIC_ENTRIES; k++) begin : g_lut
    localparam logic [16:0] Lo = logistic_entry(LOGISTIC_ENTRIES, k);
    localparam logic [16:0] Hi = logistic_entry(LOGISTIC_ENTRIES, k + 1);
    assign lut_lo[k] = Lo;
    assign lut_hi[k] = Hi;
  end

  // handshake chain
  logic [Stages:1]   vld;
  logic [Stages+1:1] adv;

  always_comb begin
    adv[Stages+1] = result.ready;
    for (int i = Stages; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= query.valid;
      end
      for (int i = 2; i <= Stages; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign query.ready  = adv[1];
  assign result.valid = vld[Stages];

  // input unpacking and asymptote clamp
  logic signed [15:0] q_theta [3];
  logic signed [15:0] q_slope [3];
  logic signed [15:0] q_load  [3];
  logic [16:0]        g_in;
  logic [16:0]        c_in;

  always_comb begin
    q_theta[0] = query.data.theta_0;
    q_theta[1] = query.data.theta_1;
    q_theta[2] = query.data.theta_2;
    q_slope[0] = query.data.slope_0;
    q_slope[1] = query.data.slope_1;
    q_slope[2] = query.data.slope_2;
    q_load[0]  = query.data.loading_0;
    q_load[1]  = query.data.loading_1;
    q_load[2]  = query.data.loading_2;
    g_in = (query.data.guess_floor > ProbOne) ? ProbOne : query.data.guess_floor;
    c_in = (query.data.slip_ceiling > ProbOne) ? ProbOne : query.data.slip_ceiling;
  end

  // stage 1: slope * loading
  logic signed [31:0] sl1  [3];
  logic signed [15:0] th1  [3];
  logic signed [15:0] dif1;
  logic [16:0]        g1;
  logic signed [17:0] cg1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int d = 0; d < 3; d++) begin
        sl1[d] <= (d < DIMS) ? q_slope[d] * q_load[d] : 32'sd0;
        th1[d] <= q_theta[d];
      end
      dif1 <= query.data.difficulty;
      g1   <= g_in;
      cg1  <= $signed({1'b0, c_in}) - $signed({1'b0, g_in});
    end
  end

  // stage 2: times theta, exact Q.36 terms
  logic signed [47:0] pr2 [3];
  logic signed [15:0] dif2;
  logic [16:0]        g2;
  logic signed [17:0] cg2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int d = 0; d < 3; d++) begin
        pr2[d] <= sl1[d] * th1[d];
      end
      dif2 <= dif1;
      g2   <= g1;
      cg2  <= cg1;
    end
  end

  // stage 3: sum, round half up to Q4.12, clip
  logic signed [49:0] sum3;
  logic signed [25:0] rnd3;
  logic signed [15:0] logit3;
  logic               sat3_next;
  logic [15:0]        u3;
  logic               sat3;
  logic [16:0]        g3;
  logic signed [17:0] cg3;

  always_comb begin
    sum3 = 50'(pr2[0]) + 50'(pr2[1]) + 50'(pr2[2]) - (50'(dif2) <<< 24)
         + (50'sd1 <<< 23);
    rnd3 = 26'(sum3 >>> 24);
    sat3_next = 1'b0;
    logit3    = rnd3[15:0];
    if (rnd3 > 26'(LogitMax)) begin
      logit3    = LogitMax;
      sat3_next = 1'b1;
    end else if (rnd3 < 26'(LogitMin)) begin
      logit3    = LogitMin;
      sat3_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      u3   <= {~logit3[15], logit3[14:0]};  // offset to [0, 65535]
      sat3 <= sat3_next;
      g3   <= g2;
      cg3  <= cg2;
    end
  end

  // stage 4: segment index and table read
  logic [TW-1:0]      t4;
  logic [KW-1:0]      k4;
  logic [16:0]        lo4;
  logic [16:0]        hi4;
  logic [15:0]        r4;
  logic               sat4;
  logic [16:0]        g4;
  logic signed [17:0] cg4;

  assign t4 = TW'(u3) * TW'(LOGISTIC_ENTRIES);
  assign k4 = t4[TW-1:16];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      lo4  <= lut_lo[k4];
      hi4  <= lut_hi[k4];
      r4   <= t4[15:0];
      sat4 <= sat3;
      g4   <= g3;
      cg4  <= cg3;
    end
  end

  // stage 5: linear interpolation, table is non-decreasing
  logic [16:0]        dl5;
  logic [32:0]        ip5;
  logic [32:0]        ipr5;
  logic [16:0]        p5;
  logic               sat5;
  logic [16:0]        g5;
  logic signed [17:0] cg5;

  always_comb begin
    dl5  = hi4 - lo4;
    ip5  = 33'(dl5) * 33'(r4);
    ipr5 = (ip5 + 33'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      p5   <= lo4 + ipr5[16:0];
      sat5 <= sat4;
      g5   <= g4;
      cg5  <= cg4;
    end
  end

  // stage 6: floor + (ceiling - floor) * p, rounded
  logic signed [35:0] acc6;
  logic signed [35:0] val6;
  logic [16:0]        prob6;
  logic               sat6;

  always_comb begin
    acc6 = 36'(cg5) * 36'($signed({1'b0, p5})) + $signed({3'b000, g5, 16'd0})
         + 36'sd32768;
    val6 = acc6 >>> 16;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      prob6 <= val6[16:0];
      sat6  <= sat5;
    end
  end

  assign result.data.probability     = prob6;
  assign result.data.logit_saturated = sat6;

endmodule
